// ===== sv/uvsq_pkg.sv =====
// Shared types and constants of the UV-sphere quad vertex generator.
// Holds the divider and CORDIC lane types, the arctangent table and register indexes.
// Used by every module of the block; depends on nothing.
package uvsq_pkg;

   // Restoring divider lane: numerator, partial remainder, quotient tail.
   localparam int NUM_W     = 41;
   localparam int DIV_W     = 10;
   localparam int QUO_W     = 32;
   localparam int DIV_STEPS = NUM_W;

   typedef struct packed {
      logic [DIV_W-1:0] rem;
      logic [NUM_W-1:0] num;
      logic [QUO_W-1:0] quo;
   } div_lane_type;

   // CORDIC lane in Q2.30 with a signed residual phase.
   localparam int CXY_W        = 34;
   localparam int CZ_W         = 33;
   localparam int CORDIC_STEPS = 30;
   localparam logic [31:0] CORDIC_START = 32'd652032874;

   typedef struct packed {
      logic signed [CXY_W-1:0] x;
      logic signed [CXY_W-1:0] y;
      logic signed [CZ_W-1:0]  z;
   } cordic_lane_type;

   localparam logic [31:0] CORDIC_ARC [CORDIC_STEPS] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
      32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
      32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
      32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
      32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
   };

   // Quadrant codes taken from the top two phase bits.
   localparam logic [1:0] QUAD_FIRST  = 2'd0;
   localparam logic [1:0] QUAD_SECOND = 2'd1;
   localparam logic [1:0] QUAD_THIRD  = 2'd2;
   localparam logic [1:0] QUAD_FOURTH = 2'd3;

   // Register indexes of the configuration port.
   localparam logic [1:0] CSR_SEGMENTS = 2'd0;
   localparam logic [1:0] CSR_RADIUS   = 2'd1;

   // Corner order v1,v2,v3,v3,v4,v1: bit k says whether corner k steps row or column.
   localparam logic [5:0] CORNER_ROW_STEP = 6'b001110;
   localparam logic [5:0] CORNER_COL_STEP = 6'b011100;
   localparam logic [2:0] CORNER_LAST     = 3'd5;

   localparam int TEX_W = 17;
   localparam logic [TEX_W-1:0] TEX_ONE = 17'd65536;

   typedef struct packed {
      logic [2:0] corner;
      logic       last;
   } vtx_tag_type;

   typedef struct packed {
      logic [2:0]       corner;
      logic             last;
      logic [1:0]       quad_ring;
      logic [1:0]       quad_seg;
      logic [TEX_W-1:0] tex_u;
      logic [TEX_W-1:0] tex_v;
   } trig_tag_type;

endpackage

// ===== sv/uv_sphere_quad_vertex_generator.sv =====
// UV-sphere quad vertex generator: one quad word in, six vertex words out.
// Depends on uvsq_pkg, uvsq_div_cell and uvsq_cordic_cell.
// Throughput: one vertex per cycle while the output is not stalled, set by the single output port.
// Reset clears the pipeline valid bits and loads segments = 32 and radius = 1.0 (Q8.8).
module uv_sphere_quad_vertex_generator
   import uvsq_pkg::*;
#(
   parameter int MAX_SEGMENTS   = 256,
   parameter int TRIG_FRAC_BITS = 14
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_ring_row,
   input  logic [7:0]         req_seg_col,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [16:0] rsp_pos_x,
   output logic signed [16:0] rsp_pos_y,
   output logic signed [16:0] rsp_pos_z,
   output logic [16:0]        rsp_tex_u,
   output logic [16:0]        rsp_tex_v,
   output logic [2:0]         rsp_corner,
   output logic               rsp_last
);

   // The segment count register is 9 bits wide, so a cap above 511 never bites.
   localparam int SEG_CAP = (MAX_SEGMENTS > 511) ? 511 : MAX_SEGMENTS;
   localparam int SC_W    = TRIG_FRAC_BITS + 2;
   localparam int SC_SH   = 30 - TRIG_FRAC_BITS;
   localparam int PX_W    = 18 + SC_W;
   localparam int LANES   = 4;
   localparam int LANE_RING = 0;
   localparam int LANE_SEG  = 1;
   localparam int LANE_TEXV = 2;
   localparam int LANE_TEXU = 3;
   localparam logic signed [CXY_W-1:0] TRIG_ONE  = CXY_W'(1) <<< TRIG_FRAC_BITS;
   localparam logic signed [CXY_W-1:0] TRIG_HALF = CXY_W'(1) <<< (SC_SH - 1);
   localparam logic signed [PX_W-1:0]  POS_HALF  = PX_W'(1) <<< (TRIG_FRAC_BITS - 1);
   localparam logic signed [PX_W-1:0]  POS_MAX   = PX_W'(65535);

   // ---------------------------------------------------------------------
   // Configuration registers. The user must write them only while the block
   // is idle; the block does not enforce this. Every stage reads them directly.
   // ---------------------------------------------------------------------
   logic [8:0]  segments_ff;
   logic [15:0] radius_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         segments_ff <= 9'd32;
         radius_ff   <= 16'd256;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CSR_SEGMENTS) begin
            segments_ff <= csr_wdata[8:0];
         end else if (csr_index == CSR_RADIUS) begin
            radius_ff <= csr_wdata;
         end
      end
   end

   logic [8:0] n_eff;
   logic [8:0] n_half;

   always_comb begin
      if (segments_ff == 9'd0) begin
         n_eff = 9'd1;
      end else if (segments_ff > 9'(SEG_CAP)) begin
         n_eff = 9'(SEG_CAP);
      end else begin
         n_eff = segments_ff;
      end
      n_half = n_eff >> 1;
   end

   // ---------------------------------------------------------------------
   // The whole chain advances together; it holds only while a finished
   // vertex word waits at the output.
   // ---------------------------------------------------------------------
   logic rsp_valid_ff;
   logic adv;

   assign adv = !rsp_valid_ff || rsp_ready;

   // ---------------------------------------------------------------------
   // Corner sequencer. It holds one quad and issues its six corners, one
   // per advancing cycle. The next quad is taken while the sixth corner
   // issues, so quads follow each other without a gap.
   // ---------------------------------------------------------------------
   logic       busy_ff;
   logic [2:0] corner_ff;
   logic [7:0] row_ff;
   logic [7:0] col_ff;
   logic       issue;

   assign issue     = busy_ff && adv;
   assign req_ready = adv && (!busy_ff || corner_ff == CORNER_LAST);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         corner_ff <= 3'd0;
      end else if (req_valid && req_ready) begin
         busy_ff   <= 1'b1;
         corner_ff <= 3'd0;
      end else if (issue) begin
         if (corner_ff == CORNER_LAST) begin
            busy_ff <= 1'b0;
         end else begin
            corner_ff <= corner_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         row_ff <= req_ring_row;
         col_ff <= req_seg_col;
      end
   end

   logic [8:0] grid_i;
   logic [8:0] grid_j;

   assign grid_i = {1'b0, row_ff} + 9'(CORNER_ROW_STEP[corner_ff]);
   assign grid_j = {1'b0, col_ff} + 9'(CORNER_COL_STEP[corner_ff]);

   // ---------------------------------------------------------------------
   // Divider chain: four lanes of 41 restoring cells. The ring phase is
   // (i*2^32 + N) / 2N, the segment phase (j*2^32 + N/2) / N, and the
   // texture coordinates (k*65536 + N/2) / N. Only the low 32 quotient
   // bits are kept, which wraps the phases modulo one turn.
   // ---------------------------------------------------------------------
   div_lane_type     div_start [LANES];
   logic [DIV_W-1:0] divisor   [LANES];
   div_lane_type     div_lane  [LANES][DIV_STEPS];

   always_comb begin
      div_start[LANE_RING].num = {grid_i, 32'd0} + NUM_W'(n_eff);
      div_start[LANE_SEG].num  = {grid_j, 32'd0} + NUM_W'(n_half);
      div_start[LANE_TEXV].num = NUM_W'({grid_i, 16'd0}) + NUM_W'(n_half);
      div_start[LANE_TEXU].num = NUM_W'({grid_j, 16'd0}) + NUM_W'(n_half);
      for (int l = 0; l < LANES; l++) begin
         div_start[l].rem = '0;
         div_start[l].quo = '0;
      end
      divisor[LANE_RING] = {n_eff, 1'b0};
      divisor[LANE_SEG]  = {1'b0, n_eff};
      divisor[LANE_TEXV] = {1'b0, n_eff};
      divisor[LANE_TEXU] = {1'b0, n_eff};
   end

   for (genvar l = 0; l < LANES; l++) begin : g_div_lane
      for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div_cell
         if (k == 0) begin : g_first
            uvsq_div_cell u_cell (
               .clock     (clock),
               .adv       (adv),
               .divisor   (divisor[l]),
               .prev_lane (div_start[l]),
               .lane_out  (div_lane[l][k])
            );
         end else begin : g_next
            uvsq_div_cell u_cell (
               .clock     (clock),
               .adv       (adv),
               .divisor   (divisor[l]),
               .prev_lane (div_lane[l][k-1]),
               .lane_out  (div_lane[l][k])
            );
         end
      end
   end

   // Valid bits and corner tags travel beside the divider cells.
   logic        div_vld_ff [DIV_STEPS];
   vtx_tag_type div_tag_ff [DIV_STEPS];
   vtx_tag_type issue_tag;

   assign issue_tag.corner = corner_ff;
   assign issue_tag.last   = corner_ff == CORNER_LAST;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_STEPS; k++) begin
            div_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         div_vld_ff[0] <= issue;
         for (int k = 1; k < DIV_STEPS; k++) begin
            div_vld_ff[k] <= div_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         div_tag_ff[0] <= issue_tag;
         for (int k = 1; k < DIV_STEPS; k++) begin
            div_tag_ff[k] <= div_tag_ff[k-1];
         end
      end
   end

   // ---------------------------------------------------------------------
   // Texture coordinates saturate: v at one, u at zero. The phase's top
   // two bits pick the quadrant; the rest feeds the CORDIC rotation.
   // ---------------------------------------------------------------------
   logic [QUO_W-1:0] phase_ring;
   logic [QUO_W-1:0] phase_seg;
   logic [QUO_W-1:0] quo_v;
   logic [QUO_W-1:0] quo_u;
   cordic_lane_type  cordic_start [2];
   trig_tag_type     trig_start;

   always_comb begin
      phase_ring = div_lane[LANE_RING][DIV_STEPS-1].quo;
      phase_seg  = div_lane[LANE_SEG][DIV_STEPS-1].quo;
      quo_v      = div_lane[LANE_TEXV][DIV_STEPS-1].quo;
      quo_u      = div_lane[LANE_TEXU][DIV_STEPS-1].quo;
      trig_start.corner    = div_tag_ff[DIV_STEPS-1].corner;
      trig_start.last      = div_tag_ff[DIV_STEPS-1].last;
      trig_start.quad_ring = phase_ring[31:30];
      trig_start.quad_seg  = phase_seg[31:30];
      trig_start.tex_v     = (quo_v > QUO_W'(TEX_ONE)) ? TEX_ONE : quo_v[TEX_W-1:0];
      trig_start.tex_u     = (quo_u > QUO_W'(TEX_ONE)) ? '0 : TEX_ONE - quo_u[TEX_W-1:0];
      cordic_start[0].x = CXY_W'(CORDIC_START);
      cordic_start[0].y = '0;
      cordic_start[0].z = CZ_W'(phase_ring[29:0]);
      cordic_start[1].x = CXY_W'(CORDIC_START);
      cordic_start[1].y = '0;
      cordic_start[1].z = CZ_W'(phase_seg[29:0]);
   end

   // ---------------------------------------------------------------------
   // CORDIC chain: two lanes (ring angle, segment angle) of 30 cells.
   // ---------------------------------------------------------------------
   cordic_lane_type cordic_lane [2][CORDIC_STEPS];

   for (genvar l = 0; l < 2; l++) begin : g_cordic_lane
      for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic_cell
         if (k == 0) begin : g_first
            uvsq_cordic_cell #(.STEP(k)) u_cell (
               .clock     (clock),
               .adv       (adv),
               .prev_lane (cordic_start[l]),
               .lane_out  (cordic_lane[l][k])
            );
         end else begin : g_next
            uvsq_cordic_cell #(.STEP(k)) u_cell (
               .clock     (clock),
               .adv       (adv),
               .prev_lane (cordic_lane[l][k-1]),
               .lane_out  (cordic_lane[l][k])
            );
         end
      end
   end

   logic         cordic_vld_ff [CORDIC_STEPS];
   trig_tag_type cordic_tag_ff [CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CORDIC_STEPS; k++) begin
            cordic_vld_ff[k] <= 1'b0;
         end
      end else if (adv) begin
         cordic_vld_ff[0] <= div_vld_ff[DIV_STEPS-1];
         for (int k = 1; k < CORDIC_STEPS; k++) begin
            cordic_vld_ff[k] <= cordic_vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cordic_tag_ff[0] <= trig_start;
         for (int k = 1; k < CORDIC_STEPS; k++) begin
            cordic_tag_ff[k] <= cordic_tag_ff[k-1];
         end
      end
   end

   // Rounds a Q2.30 value half up to the trig fraction width and clamps to [-1, +1].
   function automatic logic signed [SC_W-1:0] trig_round(input logic signed [CXY_W-1:0] v);
      logic signed [CXY_W-1:0] t;
      begin
         t = (v + TRIG_HALF) >>> SC_SH;
         if (t > TRIG_ONE) begin
            t = TRIG_ONE;
         end else if (t < -TRIG_ONE) begin
            t = -TRIG_ONE;
         end
         return SC_W'(t);
      end
   endfunction

   // Folds the first-quadrant rotation into the full circle; returns {sine, cosine}.
   function automatic logic [2*SC_W-1:0] trig_fold(input cordic_lane_type l,
                                                  input logic [1:0] q);
      logic signed [CXY_W-1:0] c;
      logic signed [CXY_W-1:0] s;
      begin
         unique case (q)
            QUAD_FIRST: begin
               c = l.x;
               s = l.y;
            end
            QUAD_SECOND: begin
               c = -l.y;
               s = l.x;
            end
            QUAD_THIRD: begin
               c = -l.x;
               s = -l.y;
            end
            QUAD_FOURTH: begin
               c = l.y;
               s = -l.x;
            end
            default: begin
               c = l.x;
               s = l.y;
            end
         endcase
         return {trig_round(s), trig_round(c)};
      end
   endfunction

   // Drops the trig fraction bits rounding half up, then clamps to the Q9.8 range.
   function automatic logic signed [16:0] pos_round(input logic signed [PX_W-1:0] p);
      logic signed [PX_W-1:0] t;
      begin
         t = (p + POS_HALF) >>> TRIG_FRAC_BITS;
         if (t > POS_MAX) begin
            t = POS_MAX;
         end else if (t < -POS_MAX) begin
            t = -POS_MAX;
         end
         return 17'(t);
      end
   endfunction

   // ---------------------------------------------------------------------
   // Stage 1: quadrant fold and rounding of both sine/cosine pairs.
   // ---------------------------------------------------------------------
   logic                   s1_vld_ff;
   trig_tag_type           s1_tag_ff;
   logic signed [SC_W-1:0] sin_ring_ff;
   logic signed [SC_W-1:0] cos_ring_ff;
   logic signed [SC_W-1:0] sin_seg_ff;
   logic signed [SC_W-1:0] cos_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (adv) begin
         s1_vld_ff <= cordic_vld_ff[CORDIC_STEPS-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_tag_ff <= cordic_tag_ff[CORDIC_STEPS-1];
         {sin_ring_ff, cos_ring_ff} <= trig_fold(cordic_lane[0][CORDIC_STEPS-1],
                                                 cordic_tag_ff[CORDIC_STEPS-1].quad_ring);
         {sin_seg_ff, cos_seg_ff}   <= trig_fold(cordic_lane[1][CORDIC_STEPS-1],
                                                 cordic_tag_ff[CORDIC_STEPS-1].quad_seg);
      end
   end

   // ---------------------------------------------------------------------
   // Stage 2: ring radius R*sin and height R*cos. Both operands are widened
   // to the product width first so the full product is kept.
   // ---------------------------------------------------------------------
   logic signed [16:0]     radius_s;
   logic signed [PX_W-1:0] prod_rs;
   logic signed [PX_W-1:0] prod_y;

   assign radius_s = $signed({1'b0, radius_ff});
   assign prod_rs  = PX_W'(radius_s) * PX_W'(sin_ring_ff);
   assign prod_y   = PX_W'(radius_s) * PX_W'(cos_ring_ff);

   logic                   s2_vld_ff;
   trig_tag_type           s2_tag_ff;
   logic signed [17:0]     ring_r_ff;
   logic signed [16:0]     pos_y_ff;
   logic signed [SC_W-1:0] s2_sin_seg_ff;
   logic signed [SC_W-1:0] s2_cos_seg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_vld_ff <= 1'b0;
      end else if (adv) begin
         s2_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_tag_ff     <= s1_tag_ff;
         ring_r_ff     <= 18'(pos_round(prod_rs));
         pos_y_ff      <= pos_round(prod_y);
         s2_sin_seg_ff <= sin_seg_ff;
         s2_cos_seg_ff <= cos_seg_ff;
      end
   end

   // ---------------------------------------------------------------------
   // Stage 3 (output word): x and z from the ring radius and segment angle.
   // ---------------------------------------------------------------------
   logic signed [PX_W-1:0] prod_x;
   logic signed [PX_W-1:0] prod_z;

   assign prod_x = PX_W'(ring_r_ff) * PX_W'(s2_sin_seg_ff);
   assign prod_z = PX_W'(ring_r_ff) * PX_W'(s2_cos_seg_ff);

   logic signed [16:0] pos_x_ff;
   logic signed [16:0] pos_y_out_ff;
   logic signed [16:0] pos_z_ff;
   trig_tag_type       out_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= s2_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pos_x_ff     <= pos_round(prod_x);
         pos_z_ff     <= pos_round(prod_z);
         pos_y_out_ff <= pos_y_ff;
         out_tag_ff   <= s2_tag_ff;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_pos_x  = pos_x_ff;
   assign rsp_pos_y  = pos_y_out_ff;
   assign rsp_pos_z  = pos_z_ff;
   assign rsp_tex_u  = out_tag_ff.tex_u;
   assign rsp_tex_v  = out_tag_ff.tex_v;
   assign rsp_corner = out_tag_ff.corner;
   assign rsp_last   = out_tag_ff.last;

endmodule

// ===== sv/uvsq_div_cell.sv =====
// One step of a restoring divider chain: produces one quotient bit per cycle while adv is high.
// Depends on uvsq_pkg for the lane type and widths.
module uvsq_div_cell
   import uvsq_pkg::*;
(
   input  logic             clock,
   input  logic             adv,
   input  logic [DIV_W-1:0] divisor,
   input  div_lane_type     prev_lane,
   output div_lane_type     lane_out
);

   div_lane_type     lane_ff;
   div_lane_type     lane_in;
   logic [DIV_W:0]   trial;
   logic             fits;

   always_comb begin
      trial       = {prev_lane.rem, prev_lane.num[NUM_W-1]};
      fits        = trial >= {1'b0, divisor};
      lane_in.rem = fits ? DIV_W'(trial - {1'b0, divisor}) : trial[DIV_W-1:0];
      lane_in.num = {prev_lane.num[NUM_W-2:0], 1'b0};
      lane_in.quo = {prev_lane.quo[QUO_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

// ===== sv/uvsq_cordic_cell.sv =====
// One rotation step of the CORDIC chain, with its arctangent taken from the package.
// Depends on uvsq_pkg for the lane type and the arctangent table.
module uvsq_cordic_cell
   import uvsq_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic            clock,
   input  logic            adv,
   input  cordic_lane_type prev_lane,
   output cordic_lane_type lane_out
);

   localparam logic signed [CZ_W-1:0] ARC = CZ_W'(CORDIC_ARC[STEP]);

   cordic_lane_type         lane_ff;
   cordic_lane_type         lane_in;
   logic signed [CXY_W-1:0] dx;
   logic signed [CXY_W-1:0] dy;

   always_comb begin
      dx = prev_lane.y >>> STEP;
      dy = prev_lane.x >>> STEP;
      if (!prev_lane.z[CZ_W-1]) begin
         lane_in.x = prev_lane.x - dx;
         lane_in.y = prev_lane.y + dy;
         lane_in.z = prev_lane.z - ARC;
      end else begin
         lane_in.x = prev_lane.x + dx;
         lane_in.y = prev_lane.y - dy;
         lane_in.z = prev_lane.z + ARC;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lane_ff <= lane_in;
      end
   end

   assign lane_out = lane_ff;

endmodule

// ===== tb/uvsq_vertex_checker.sv =====
// Checker for the UV-sphere quad vertex generator: watches the csr, req and rsp channels.
// It predicts the six vertices of every quad taken and compares them with the returned words.
// Depends on uvsq_pkg for the arctangent table, the CORDIC start value and register indexes.
module uvsq_vertex_checker
   import uvsq_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [7:0]         req_ring_row,
   input  logic [7:0]         req_seg_col,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [16:0] rsp_pos_x,
   input  logic signed [16:0] rsp_pos_y,
   input  logic signed [16:0] rsp_pos_z,
   input  logic [16:0]        rsp_tex_u,
   input  logic [16:0]        rsp_tex_v,
   input  logic [2:0]         rsp_corner,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 14;
   localparam longint POS_MAX = 65535;

   typedef struct packed {
      logic [16:0] pos_x;
      logic [16:0] pos_y;
      logic [16:0] pos_z;
      logic [16:0] tex_u;
      logic [16:0] tex_v;
      logic [2:0]  corner;
      logic        last;
   } vertex_type;

   vertex_type vertex_queue[$];
   logic [8:0]  seg_reg;
   logic [15:0] rad_reg;

   function automatic longint round_shift(longint v, int k);
      return (v + (longint'(1) << (k - 1))) >>> k;
   endfunction

   function automatic longint clip(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   task automatic phase_sincos(input logic [31:0] p, output longint sn, output longint cs);
      longint x, y, z, dx, dy, c, s;
      longint one;
      one = longint'(1) << FRAC;
      x = CORDIC_START;
      y = 0;
      z = longint'(p[29:0]);
      for (int k = 0; k < CORDIC_STEPS; k++) begin
         dx = y >>> k;
         dy = x >>> k;
         if (z >= 0) begin
            x = x - dx; y = y + dy; z = z - longint'(CORDIC_ARC[k]);
         end else begin
            x = x + dx; y = y - dy; z = z + longint'(CORDIC_ARC[k]);
         end
      end
      case (p[31:30])
         QUAD_FIRST:  begin c = x;  s = y;  end
         QUAD_SECOND: begin c = -y; s = x;  end
         QUAD_THIRD:  begin c = -x; s = -y; end
         default:     begin c = y;  s = -x; end
      endcase
      cs = clip(round_shift(c, 30 - FRAC), -one, one);
      sn = clip(round_shift(s, 30 - FRAC), -one, one);
   endtask

   task automatic grid_point(input longint n, input longint i, input longint j,
                             inout vertex_type vtx);
      longint unsigned pr, pc;
      longint sr, cr, sc, cc, rs, r, u, v;
      pr = ((longint'(i) << 32) + n) / (2 * n);
      pc = ((longint'(j) << 32) + (n >> 1)) / n;
      r = longint'(rad_reg);
      phase_sincos(pr[31:0], sr, cr);
      phase_sincos(pc[31:0], sc, cc);
      rs = round_shift(r * sr, FRAC);
      vtx.pos_x = 17'(clip(round_shift(rs * sc, FRAC), -POS_MAX, POS_MAX));
      vtx.pos_z = 17'(clip(round_shift(rs * cc, FRAC), -POS_MAX, POS_MAX));
      vtx.pos_y = 17'(clip(round_shift(r * cr, FRAC), -POS_MAX, POS_MAX));
      v = (i * 65536 + (n >> 1)) / n;
      u = 65536 - (j * 65536 + (n >> 1)) / n;
      vtx.tex_u = 17'(clip(u, 0, 65536));
      vtx.tex_v = 17'(clip(v, 0, 65536));
   endtask

   task automatic queue_quad(input logic [7:0] row, input logic [7:0] col);
      vertex_type vtx;
      longint n;
      n = seg_reg;
      if (n < 1) n = 1;
      if (n > 256) n = 256;
      for (int k = 0; k < 6; k++) begin
         vtx = '0;
         grid_point(n, longint'(row) + CORNER_ROW_STEP[k], longint'(col) + CORNER_COL_STEP[k],
                    vtx);
         vtx.corner = 3'(k);
         vtx.last = (3'(k) == CORNER_LAST);
         vertex_queue.push_back(vtx);
      end
   endtask

   task automatic check_field(string name, logic [16:0] want, logic [16:0] got);
      if (want !== got) begin
         fail_count++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   initial fail_count = 0;
   assign pending = vertex_queue.size();

   always @(posedge clock) begin
      vertex_type want;
      if (reset) begin
         seg_reg <= 9'd32;
         rad_reg <= 16'd256;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_SEGMENTS) seg_reg <= csr_wdata[8:0];
            else if (csr_index == CSR_RADIUS) rad_reg <= csr_wdata;
         end
         if (req_valid && req_ready) queue_quad(req_ring_row, req_seg_col);
         if (rsp_valid && rsp_ready) begin
            if (vertex_queue.size() == 0) begin
               fail_count++;
               $display("%0t: vertex word with none expected, corner %0d", $time, rsp_corner);
            end else begin
               want = vertex_queue.pop_front();
               check_field("pos_x", want.pos_x, rsp_pos_x);
               check_field("pos_y", want.pos_y, rsp_pos_y);
               check_field("pos_z", want.pos_z, rsp_pos_z);
               check_field("tex_u", want.tex_u, rsp_tex_u);
               check_field("tex_v", want.tex_v, rsp_tex_v);
               check_field("corner", 17'(want.corner), 17'(rsp_corner));
               check_field("last", 17'(want.last), 17'(rsp_last));
            end
         end
      end
   end

endmodule

// ===== tb/uv_sphere_quad_vertex_generator_tb.sv =====
// Top of the testbench for the UV-sphere quad vertex generator: clock, reset and stimulus.
// Depends on uvsq_pkg, the block itself and uvsq_vertex_checker, which does all comparing.
module uv_sphere_quad_vertex_generator_tb
   import uvsq_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   // The drain wait leaves margin beyond the block's worst path.
   localparam int DRAIN_CYCLES = 100;
   localparam int CYCLE_LIMIT  = 400000;

   logic               clock;
   logic               reset;
   logic               csr_valid;
   logic               csr_ready;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;
   logic               req_valid;
   logic               req_ready;
   logic [7:0]         req_ring_row;
   logic [7:0]         req_seg_col;
   logic               rsp_valid;
   logic               rsp_ready;
   logic signed [16:0] rsp_pos_x;
   logic signed [16:0] rsp_pos_y;
   logic signed [16:0] rsp_pos_z;
   logic [16:0]        rsp_tex_u;
   logic [16:0]        rsp_tex_v;
   logic [2:0]         rsp_corner;
   logic               rsp_last;
   int                 fail_count;
   int                 pending;

   // Idle percentages of the two sides, changed only by the main stimulus process.
   int  sender_idle_pct;
   int  receiver_stall_pct;
   // Each toggle asks the receiver process for one long hold-off.
   logic hold_toggle;
   int   cycle_count;
   // Effective ring count, mirrored here only to aim random quads inside the grid.
   int   grid_n;

   uv_sphere_quad_vertex_generator i_dut (.*);

   uvsq_vertex_checker i_checker (.*);

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count > CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // The receiver drives rsp_ready on falling edges. A long hold-off keeps ready low while
   // the sender keeps offering quads, so the pipeline fills and req_ready must drop.
   initial begin
      int   hold_left;
      logic seen_toggle;
      rsp_ready = 1'b0;
      hold_left = 0;
      seen_toggle = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_toggle !== seen_toggle) begin
            seen_toggle = hold_toggle;
            hold_left = 600;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   // Offers one quad word, with random idle cycles first, and returns at the accepting edge.
   task automatic send_quad(input logic [7:0] row, input logic [7:0] col);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_ring_row <= row;
      req_seg_col <= col;
      do @(posedge clock); while (!req_ready);
   endtask

   // Waits until every expected vertex has come back, then lets the pipeline settle.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_SEGMENTS) begin
         grid_n = (data[8:0] == 0) ? 1 : (data[8:0] > 256 ? 256 : data[8:0]);
      end
   endtask

   // Most quads lie inside the grid; the rest use any index so the phases wrap.
   task automatic send_random_quad;
      if ($urandom_range(99) < 75) begin
         send_quad(8'($urandom_range(grid_n - 1)), 8'($urandom_range(grid_n - 1)));
      end else begin
         send_quad(8'($urandom_range(255)), 8'($urandom_range(255)));
      end
   endtask

   initial begin
      logic [15:0] seg_pick [8];
      logic [15:0] rad_pick [8];
      seg_pick = '{16'd256, 16'd1, 16'd2, 16'd0, 16'd511, 16'd32, 16'd7, 16'd200};
      rad_pick = '{16'd65535, 16'd0, 16'd256, 16'd1, 16'd40000, 16'd12345, 16'd65535, 16'd512};
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_index = CSR_SEGMENTS;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_ring_row = '0;
      req_seg_col = '0;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      hold_toggle = 1'b0;
      grid_n = 32;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed quads at the reset setting: grid corners, the poles and the seam,
      // and indices at or beyond N where the angles wrap and u and v saturate.
      send_quad(8'd0, 8'd0);
      send_quad(8'd31, 8'd31);
      send_quad(8'd0, 8'd31);
      send_quad(8'd31, 8'd0);
      send_quad(8'd15, 8'd16);
      send_quad(8'd32, 8'd32);
      send_quad(8'd255, 8'd255);
      send_quad(8'd170, 8'd85);
      send_quad(8'd85, 8'd170);
      drain();

      // Unknown register indexes must be ignored, then the extremes of both registers.
      write_csr(2'd2, 16'hFFFF);
      write_csr(2'd3, 16'h0000);
      write_csr(CSR_SEGMENTS, 16'd256);
      write_csr(CSR_RADIUS, 16'd65535);
      send_quad(8'd0, 8'd0);
      send_quad(8'd255, 8'd255);
      send_quad(8'd127, 8'd128);
      send_quad(8'd64, 8'd192);
      drain();
      write_csr(CSR_SEGMENTS, 16'd0);
      write_csr(CSR_RADIUS, 16'd0);
      send_quad(8'd0, 8'd0);
      send_quad(8'd1, 8'd3);
      drain();
      write_csr(CSR_SEGMENTS, 16'h01FF);
      write_csr(CSR_RADIUS, 16'd256);
      send_quad(8'd255, 8'd0);
      send_quad(8'd0, 8'd255);
      drain();
      write_csr(CSR_SEGMENTS, 16'hFE01);
      send_quad(8'd0, 8'd1);
      drain();

      // Random phases cycle through the four idling patterns over varied settings.
      for (int ph = 0; ph < 8; ph++) begin
         write_csr(CSR_SEGMENTS, (ph == 7) ? 16'($urandom_range(3, 255)) : seg_pick[ph]);
         write_csr(CSR_RADIUS, (ph == 7) ? 16'($urandom_range(65535)) : rad_pick[ph]);
         case (ph % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 0;  receiver_stall_pct = 66; end
            2: begin sender_idle_pct = 66; receiver_stall_pct = 0;  end
            default: begin sender_idle_pct = 9; receiver_stall_pct = 9; end
         endcase
         if (ph == 0 || ph == 5) hold_toggle = ~hold_toggle;
         repeat (50) send_random_quad();
         drain();
      end

      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
sv/uvsq_pkg.sv
sv/uvsq_div_cell.sv
sv/uvsq_cordic_cell.sv
sv/uv_sphere_quad_vertex_generator.sv
tb/uvsq_vertex_checker.sv
tb/uv_sphere_quad_vertex_generator_tb.sv
